// ===== design/assert_macros.svh =====
// Assertion macros used by the rasterizer controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define TLR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define TLR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tlr_pkg.sv =====
// Shared types, widths and codes of the thick line rasterizer.
package tlr_pkg;

  localparam int FRACTION_BITS  = 4;
  localparam int SUB            = FRACTION_BITS + 1;   // internal units: half a raw LSB
  localparam int STEP           = 1 << SUB;            // one pixel in internal units
  localparam int PIXEL_BITS_DEF = 8;

  localparam int COORD_W = 12;   // raw endpoint field
  localparam int CI_W    = 13;   // endpoint in internal units
  localparam int W_W     = 8;    // stroke width field
  localparam int K_W     = 9;    // column / row index
  localparam int CNT_W   = 14;   // column count arithmetic
  localparam int RAD_W   = 28;   // square root radicand
  localparam int ROOT_W  = 14;   // square root result
  localparam int DVD_W   = 27;   // dividend
  localparam int DVS_W   = 13;   // divisor
  localparam int Q_W     = 14;   // useful quotient bits for a column center
  localparam int S_W     = 9;    // span half-length
  localparam int VAL_W   = 18;   // signed positions
  localparam int DX_W    = 11;   // disc column offset
  localparam int SQ_W    = 20;   // disc radicand before clipping
  localparam int MAJ_W   = 10;   // major pixel sum

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_END   = 2'd1,
    PH_BODY  = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    CMD_NONE       = 4'd0,
    CMD_LOAD       = 4'd1,
    CMD_EMIT       = 4'd2,
    CMD_LEN_MUL    = 4'd3,
    CMD_SPAN_MUL   = 4'd4,
    CMD_SPAN_SET   = 4'd5,
    CMD_NEXT_PHASE = 4'd6,
    CMD_DISC_MUL   = 4'd7,
    CMD_BODY_MUL   = 4'd8,
    CMD_OPEN       = 4'd9,
    CMD_NEXT_COL   = 4'd10,
    CMD_RESP       = 4'd11
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic phase_done;
    logic k_ge_count;
    logic phase_body;
    logic sqrt_done;
    logic div_done;
    logic col_open;
    logic adv_needed;
    logic out_free;
  } dp_status_t;

endpackage

// ===== design/tlr_in_if.sv =====
// Input channel: line loads and pixel fetches.
interface tlr_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [tlr_pkg::COORD_W-1:0] x_start;
  logic [tlr_pkg::COORD_W-1:0] y_start;
  logic [tlr_pkg::COORD_W-1:0] x_end;
  logic [tlr_pkg::COORD_W-1:0] y_end;
  logic [tlr_pkg::W_W-1:0]     stroke_width;

  modport source (output valid, op, x_start, y_start, x_end, y_end, stroke_width,
                  input ready);
  modport sink   (input valid, op, x_start, y_start, x_end, y_end, stroke_width,
                  output ready);
endinterface

// ===== design/tlr_out_if.sv =====
// Result channel: one pixel word per input word.
interface tlr_out_if #(
  parameter int PIXEL_BITS = tlr_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_x;
  logic [PIXEL_BITS-1:0] pixel_y;
  logic                  pixel_valid;
  logic                  done_res;

  modport source (output valid, pixel_x, pixel_y, pixel_valid, done_res, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_valid, done_res, output ready);
endinterface

// ===== design/tlr_sqrt.sv =====
// Iterative floor square root, one result bit per cycle.
module tlr_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tlr_pkg::RAD_W-1:0]   radicand,
  output logic                        done,
  output logic [tlr_pkg::ROOT_W-1:0]  root
);
  import tlr_pkg::*;

  logic [RAD_W-1:0] v_r, r_r, bit_r;
  logic [RAD_W-1:0] trial;
  logic             fits;
  logic             busy_r, done_r;

  assign trial = r_r + bit_r;
  assign fits  = v_r >= trial;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // digit recurrence
  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= radicand;
      r_r   <= '0;
      bit_r <= RAD_W'(1) << (RAD_W - 2);
    end else if (busy_r) begin
      if (fits) begin
        v_r <= v_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[ROOT_W-1:0];
endmodule

// ===== design/tlr_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module tlr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tlr_pkg::DVD_W-1:0]  dividend,
  input  logic [tlr_pkg::DVS_W-1:0]  divisor,
  output logic                       done,
  output logic [tlr_pkg::DVD_W-1:0]  quotient
);
  import tlr_pkg::*;

  localparam int CNT_BITS = $clog2(DVD_W);

  logic [DVS_W-1:0]    rem_r;
  logic [DVD_W-1:0]    dq_r;
  logic [DVS_W-1:0]    dvs_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                busy_r, done_r;
  logic [DVS_W:0]      trial;
  logic                fits;

  assign trial = {rem_r, dq_r[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(DVD_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // shift-subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dq_r  <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= DVS_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_r <= trial[DVS_W-1:0];
      end
      dq_r <= {dq_r[DVD_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;
endmodule

// ===== design/tlr_datapath.sv =====
// Rasterizer datapath: line geometry, span registers, arithmetic units, result register.
module tlr_datapath #(
  parameter int PIXEL_BITS = tlr_pkg::PIXEL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tlr_pkg::ctrl_cmd_t           cmd,
  output tlr_pkg::dp_status_t          status,
  input  logic [tlr_pkg::COORD_W-1:0]  x_start,
  input  logic [tlr_pkg::COORD_W-1:0]  y_start,
  input  logic [tlr_pkg::COORD_W-1:0]  x_end,
  input  logic [tlr_pkg::COORD_W-1:0]  y_end,
  input  logic [tlr_pkg::W_W-1:0]      stroke_width,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [PIXEL_BITS-1:0]        pixel_x,
  output logic [PIXEL_BITS-1:0]        pixel_y,
  output logic                         pixel_valid,
  output logic                         done_res
);
  import tlr_pkg::*;

  // line registers
  logic [CI_W-1:0]  xs_r, ys_r, xe_r, ye_r;
  logic [W_W-1:0]   w_r;
  logic             horiz_r;
  logic [CI_W-1:0]  om_r, on_r, dmaj_r;
  logic [CI_W:0]    dmin_r;
  phase_t           phase_r;
  logic [K_W-1:0]   k_r;
  logic [S_W-1:0]   s_r;
  logic [VAL_W-1:0] inner_r, limit_r;
  logic [RAD_W-1:0] rad_r;
  logic [DVD_W-1:0] dvd_r;
  logic             neg_r;
  logic             sq_go_r, dv_go_r;
  logic [PIXEL_BITS-1:0] pend_x_r, pend_y_r, out_x_r, out_y_r;
  logic             pend_v_r, out_pv_r, out_done_r, out_valid_r;

  // arithmetic units
  logic              sq_done, dv_done;
  logic [ROOT_W-1:0] sq_root;
  logic [DVD_W-1:0]  quot;

  tlr_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_go_r), .radicand(rad_r),
    .done(sq_done), .root(sq_root)
  );

  tlr_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_go_r), .dividend(dvd_r), .divisor(dmaj_r),
    .done(dv_done), .quotient(quot)
  );

  // load geometry from the incoming word
  logic [CI_W-1:0] lxs, lys, lxe, lye, adx, ady;
  logic [CI_W:0]   ldx, ldy, ldmin;
  logic            lhoriz, lfrom;
  logic [CI_W-1:0] maj_s, maj_e, min_s, min_e, lom, lpm, lon, lpn;

  always_comb begin
    lxs    = {x_start, 1'b0};
    lys    = {y_start, 1'b0};
    lxe    = {x_end, 1'b0};
    lye    = {y_end, 1'b0};
    ldx    = {1'b0, lxe} - {1'b0, lxs};
    ldy    = {1'b0, lye} - {1'b0, lys};
    adx    = ldx[CI_W] ? CI_W'(-ldx) : ldx[CI_W-1:0];
    ady    = ldy[CI_W] ? CI_W'(-ldy) : ldy[CI_W-1:0];
    lhoriz = adx > ady;
    lfrom  = lhoriz ? (lxe > lxs) : (lye > lys);
    maj_s  = lhoriz ? lxs : lys;
    maj_e  = lhoriz ? lxe : lye;
    min_s  = lhoriz ? lys : lxs;
    min_e  = lhoriz ? lye : lxe;
    lom    = lfrom ? maj_s : maj_e;
    lpm    = lfrom ? maj_e : maj_s;
    lon    = lfrom ? min_s : min_e;
    lpn    = lfrom ? min_e : min_s;
    ldmin  = {1'b0, lpn} - {1'b0, lon};
  end

  // column counts and disc centers
  logic [CNT_W-1:0] disc_cnt, body_cnt, k_ext;
  logic [CI_W-1:0]  cx, cy, adm;
  logic             is_body;

  always_comb begin
    disc_cnt = (CNT_W'({w_r, 1'b0}) + CNT_W'(STEP - 1)) >> SUB;
    body_cnt = (CNT_W'(dmaj_r) + CNT_W'(STEP - 1)) >> SUB;
    k_ext    = CNT_W'(k_r);
    is_body  = phase_r == PH_BODY;
    cx       = (phase_r == PH_START) ? xs_r : xe_r;
    cy       = (phase_r == PH_START) ? ys_r : ye_r;
    adm      = dmin_r[CI_W] ? CI_W'(-dmin_r) : dmin_r[CI_W-1:0];
  end

  // radicands and dividends (multiplier outputs are registered)
  logic [2*CI_W-1:0]     maj_sq, min_sq;
  logic [2*W_W-1:0]      w_sq;
  logic [DX_W-1:0]       dx;
  logic signed [2*DX_W-1:0] dx_sq;
  logic [SQ_W-1:0]       disc_sq;
  logic [RAD_W-1:0]      disc_rad, len_rad;
  logic [W_W+ROOT_W-1:0] wl;
  logic [CI_W+K_W-1:0]   dk;

  always_comb begin
    maj_sq   = dmaj_r * dmaj_r;
    min_sq   = adm * adm;
    len_rad  = RAD_W'(maj_sq) + RAD_W'(min_sq);
    w_sq     = w_r * w_r;
    dx       = (DX_W'(k_r) << SUB) - DX_W'(w_r);
    dx_sq    = $signed(dx) * $signed(dx);
    disc_sq  = SQ_W'(w_sq) - dx_sq[SQ_W-1:0];
    disc_rad = (!disc_sq[SQ_W-1] && disc_sq != '0) ? RAD_W'(disc_sq) : '0;
    wl       = w_r * sq_root;
    dk       = adm * k_r;
  end

  // span bounds
  logic [VAL_W-1:0] h_ext, q_ext, ctr, open_inner, open_limit, xv, inner_step;
  logic             col_open;

  always_comb begin
    h_ext = VAL_W'(sq_root);
    q_ext = VAL_W'(quot[Q_W-1:0]);
    ctr   = VAL_W'(on_r) + (neg_r ? -q_ext : q_ext);
    if (is_body) begin
      open_inner = ctr - VAL_W'(s_r);
      open_limit = ctr + VAL_W'(s_r);
      col_open   = s_r != '0;
    end else begin
      open_inner = VAL_W'(cy) - h_ext;
      open_limit = VAL_W'(cy) + h_ext;
      col_open   = sq_root != '0;
    end
    xv         = VAL_W'(cx) - VAL_W'(w_r) + (VAL_W'(k_r) << SUB);
    inner_step = inner_r + VAL_W'(STEP);
  end

  // pixel of the current position
  logic [MAJ_W-1:0]      maj_sum;
  logic [VAL_W-1:0]      maj_ext;
  logic [PIXEL_BITS-1:0] maj_pix, min_pix, disc_x_pix, emit_x, emit_y;

  always_comb begin
    maj_sum    = MAJ_W'(om_r >> SUB) + MAJ_W'(k_r);
    maj_ext    = VAL_W'(maj_sum);
    maj_pix    = maj_ext[PIXEL_BITS-1:0];
    min_pix    = inner_r[SUB+PIXEL_BITS-1:SUB];
    disc_x_pix = xv[SUB+PIXEL_BITS-1:SUB];
    if (is_body) begin
      emit_x = horiz_r ? maj_pix : min_pix;
      emit_y = horiz_r ? min_pix : maj_pix;
    end else begin
      emit_x = disc_x_pix;
      emit_y = min_pix;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DONE;
      k_r     <= '0;
      sq_go_r <= 1'b0;
      dv_go_r <= 1'b0;
    end else begin
      sq_go_r <= 1'b0;
      dv_go_r <= 1'b0;
      unique case (cmd.op)
        CMD_LOAD: begin
          phase_r <= PH_START;
          k_r     <= '0;
        end
        CMD_LEN_MUL, CMD_DISC_MUL: sq_go_r <= 1'b1;
        CMD_SPAN_MUL, CMD_BODY_MUL: dv_go_r <= 1'b1;
        CMD_NEXT_PHASE: begin
          phase_r <= phase_t'(phase_r + 2'd1);
          k_r     <= '0;
        end
        CMD_OPEN: begin
          if (!col_open) k_r <= k_r + 1'b1;
        end
        CMD_NEXT_COL: k_r <= k_r + 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_LOAD: begin
        xs_r     <= lxs;
        ys_r     <= lys;
        xe_r     <= lxe;
        ye_r     <= lye;
        w_r      <= stroke_width;
        horiz_r  <= lhoriz;
        om_r     <= lom;
        on_r     <= lon;
        dmaj_r   <= lpm - lom;
        dmin_r   <= ldmin;
        pend_x_r <= '0;
        pend_y_r <= '0;
        pend_v_r <= 1'b0;
      end
      CMD_EMIT: begin
        if (phase_r == PH_DONE) begin
          pend_x_r <= '0;
          pend_y_r <= '0;
          pend_v_r <= 1'b0;
        end else begin
          pend_x_r <= emit_x;
          pend_y_r <= emit_y;
          pend_v_r <= 1'b1;
          inner_r  <= inner_step;
        end
      end
      CMD_LEN_MUL:  rad_r <= len_rad;
      CMD_DISC_MUL: rad_r <= disc_rad;
      CMD_SPAN_MUL: dvd_r <= DVD_W'(wl);
      CMD_BODY_MUL: begin
        dvd_r <= DVD_W'({dk, {SUB{1'b0}}});
        neg_r <= dmin_r[CI_W];
      end
      CMD_SPAN_SET: s_r <= (dmaj_r == '0) ? '0 : quot[S_W-1:0];
      CMD_OPEN: begin
        inner_r <= open_inner;
        limit_r <= open_limit;
      end
      CMD_RESP: begin
        out_x_r    <= pend_x_r;
        out_y_r    <= pend_y_r;
        out_pv_r   <= pend_v_r;
        out_done_r <= phase_r == PH_DONE;
      end
      default: ;
    endcase
  end

  // result register handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == CMD_RESP) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // status back to the controller
  always_comb begin
    status.phase_done = phase_r == PH_DONE;
    status.k_ge_count = is_body ? (k_ext >= body_cnt) : (k_ext >= disc_cnt);
    status.phase_body = is_body;
    status.sqrt_done  = sq_done;
    status.div_done   = dv_done;
    status.col_open   = col_open;
    status.adv_needed = (phase_r != PH_DONE) && ($signed(inner_r) >= $signed(limit_r));
    status.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid   = out_valid_r;
  assign pixel_x     = out_x_r;
  assign pixel_y     = out_y_r;
  assign pixel_valid = out_pv_r;
  assign done_res    = out_done_r;
endmodule

// ===== design/tlr_ctrl.sv =====
// Rasterizer controller: sequences loads, fetches and the span search.
`include "assert_macros.svh"
module tlr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_op,
  output logic                in_ready,
  input  tlr_pkg::dp_status_t status,
  output tlr_pkg::ctrl_cmd_t  cmd
);
  import tlr_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE      = 14'b00000000000001,
    S_LEN_MUL   = 14'b00000000000010,
    S_LEN_WAIT  = 14'b00000000000100,
    S_SPAN_MUL  = 14'b00000000001000,
    S_SPAN_WAIT = 14'b00000000010000,
    S_SPAN_SET  = 14'b00000000100000,
    S_SEEK      = 14'b00000001000000,
    S_DISC_MUL  = 14'b00000010000000,
    S_DISC_WAIT = 14'b00000100000000,
    S_BODY_MUL  = 14'b00001000000000,
    S_BODY_WAIT = 14'b00010000000000,
    S_OPEN      = 14'b00100000000000,
    S_ADV       = 14'b01000000000000,
    S_RESP      = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = state_r == S_IDLE;

  // next state and command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (op_t'(in_op) == OP_LOAD) begin
            cmd.op    = CMD_LOAD;
            state_nxt = S_LEN_MUL;
          end else begin
            cmd.op    = CMD_EMIT;
            state_nxt = S_ADV;
          end
        end
      end
      S_LEN_MUL: begin
        cmd.op    = CMD_LEN_MUL;
        state_nxt = S_LEN_WAIT;
      end
      S_LEN_WAIT: if (status.sqrt_done) state_nxt = S_SPAN_MUL;
      S_SPAN_MUL: begin
        cmd.op    = CMD_SPAN_MUL;
        state_nxt = S_SPAN_WAIT;
      end
      S_SPAN_WAIT: if (status.div_done) state_nxt = S_SPAN_SET;
      S_SPAN_SET: begin
        cmd.op    = CMD_SPAN_SET;
        state_nxt = S_SEEK;
      end
      S_SEEK: begin
        if (status.phase_done) begin
          state_nxt = S_RESP;
        end else if (status.k_ge_count) begin
          cmd.op = CMD_NEXT_PHASE;
        end else if (status.phase_body) begin
          state_nxt = S_BODY_MUL;
        end else begin
          state_nxt = S_DISC_MUL;
        end
      end
      S_DISC_MUL: begin
        cmd.op    = CMD_DISC_MUL;
        state_nxt = S_DISC_WAIT;
      end
      S_DISC_WAIT: if (status.sqrt_done) state_nxt = S_OPEN;
      S_BODY_MUL: begin
        cmd.op    = CMD_BODY_MUL;
        state_nxt = S_BODY_WAIT;
      end
      S_BODY_WAIT: if (status.div_done) state_nxt = S_OPEN;
      S_OPEN: begin
        cmd.op    = CMD_OPEN;
        state_nxt = status.col_open ? S_RESP : S_SEEK;
      end
      S_ADV: begin
        if (status.adv_needed) begin
          cmd.op    = CMD_NEXT_COL;
          state_nxt = S_SEEK;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (status.out_free) begin
          cmd.op    = CMD_RESP;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `TLR_ASSERT_IMP(a_resp_free, clk, rst_n, cmd.op == CMD_RESP, status.out_free, "result overwrote a held word")
  `TLR_ASSERT_NXT(a_accept_busy, clk, rst_n, in_valid && in_ready, state_r != S_IDLE, "accepted word left no work")
  `TLR_ASSERT_IMP(a_sqrt_wait, clk, rst_n, status.sqrt_done, state_r == S_LEN_WAIT || state_r == S_DISC_WAIT, "root finished outside a wait")
endmodule

// ===== design/thick_line_rasterizer_core.sv =====
// Top level of the thick line rasterizer with round caps.
//
//  channel  dir  handshake      word
//  in_ch    in   valid/ready    op, x_start, y_start, x_end, y_end, stroke_width
//  out_ch   out  valid/ready    pixel_x, pixel_y, pixel_valid, done_res
//
// A fetch inside a span passes through S_IDLE, S_ADV and S_RESP to the result register;
// moving to a new disc column adds a 14-step square root, a new body column a 27-step
// divider. A load runs the length square root and the span divider, then the search
// for the first covered column. Each empty column passes through the same unit again.
// Reset is synchronous, active low, and leaves no line loaded (fetches report done).
// One word is in work at a time; a finished word waits in the output register
// while the next input word is accepted and processed.
module thick_line_rasterizer_core #(
  parameter int PIXEL_BITS = tlr_pkg::PIXEL_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tlr_in_if.sink     in_ch,
  tlr_out_if.source  out_ch
);
  import tlr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tlr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tlr_datapath #(.PIXEL_BITS(PIXEL_BITS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .x_start      (in_ch.x_start),
    .y_start      (in_ch.y_start),
    .x_end        (in_ch.x_end),
    .y_end        (in_ch.y_end),
    .stroke_width (in_ch.stroke_width),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .pixel_x      (out_ch.pixel_x),
    .pixel_y      (out_ch.pixel_y),
    .pixel_valid  (out_ch.pixel_valid),
    .done_res     (out_ch.done_res)
  );
endmodule
